FILE: design/ppls_pkg.sv
// ============================================================================
// ppls_pkg
// Shared constants and types of the Phong point-light shading unit.
// ============================================================================
package ppls_pkg;

  localparam int CRD_W        = 32;  // coordinate width, signed
  localparam int COL_W        = 48;  // packed color width
  localparam int CH_W         = 16;  // one Q1.15 color channel
  localparam int MAG_W        = 33;  // magnitude of a coordinate difference
  localparam int MAG_NW       = 30;  // normalized magnitude width
  localparam int NORM_MSB     = 29;  // normalized top lies in [2^29, 2^30)
  localparam int POS_W        = 6;   // bit position within MAG_W
  localparam int SUMSQ_W      = 62;  // sum of three squares
  localparam int SQRT_STEPS   = 31;  // root bits of SUMSQ_W
  localparam int BRIGHT_W     = 32;
  localparam int BRIGHT_SHIFT = 27;
  localparam int COLOR_SHIFT  = 15;
  localparam int PACK_STAGES  = 16;  // stages after the normalizers
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;

  localparam logic [CH_W-1:0] CH_ONE    = 16'd32768;
  localparam logic [CH_W-1:0] RATIO_RST = 16'd32768;
  localparam logic [CH_W-1:0] GAIN_RST  = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_X,
    REG_LIGHT_Y,
    REG_LIGHT_Z,
    REG_LIGHT_COLOR,
    REG_AMBIENT_COLOR,
    REG_LIGHT_RATIO,
    REG_LUMEN_GAIN
  } cfg_reg_t;

endpackage

FILE: design/ppls_if.sv
// ============================================================================
// ppls_if
// Valid/ready channels for hit items and shaded colors.
// ============================================================================
interface ppls_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [ppls_pkg::CRD_W-1:0] hit_x;
  logic signed [ppls_pkg::CRD_W-1:0] hit_y;
  logic signed [ppls_pkg::CRD_W-1:0] hit_z;
  logic signed [ppls_pkg::CRD_W-1:0] normal_x;
  logic signed [ppls_pkg::CRD_W-1:0] normal_y;
  logic signed [ppls_pkg::CRD_W-1:0] normal_z;
  logic signed [ppls_pkg::CRD_W-1:0] ray_dir_x;
  logic signed [ppls_pkg::CRD_W-1:0] ray_dir_y;
  logic signed [ppls_pkg::CRD_W-1:0] ray_dir_z;
  logic [ppls_pkg::COL_W-1:0]        surface_color;
  logic                              shadowed;

  modport source (output valid, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
                  ray_dir_x, ray_dir_y, ray_dir_z, surface_color, shadowed,
                  input ready);
  modport sink   (input valid, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
                  ray_dir_x, ray_dir_y, ray_dir_z, surface_color, shadowed,
                  output ready);
endinterface

interface ppls_out_if;
  logic                      valid;
  logic                      ready;
  logic [ppls_pkg::CH_W-1:0] out_red;
  logic [ppls_pkg::CH_W-1:0] out_green;
  logic [ppls_pkg::CH_W-1:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

FILE: design/ppls_unit.sv
// ============================================================================
// ppls_unit
// Pipelined vector normalizer: block shift, sum of squares, one root bit
// per stage, then one quotient bit per stage for each component.
// All stages advance on en.
// ============================================================================
module ppls_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [ppls_pkg::MAG_W-1:0]   d_in  [3],
  output logic signed [FRAC_BITS+1:0]         u_out [3]
);

  localparam int MW  = ppls_pkg::MAG_NW;
  localparam int SW  = ppls_pkg::SUMSQ_W;
  localparam int NW  = ppls_pkg::SQRT_STEPS;
  localparam int TW  = SW + 2;
  localparam int DW  = NW + FRAC_BITS + 1;
  localparam int QW  = FRAC_BITS + 1;
  localparam int UW  = FRAC_BITS + 2;
  localparam int GW  = ppls_pkg::MAG_W;
  localparam int PW  = ppls_pkg::POS_W;

  typedef struct packed {
    logic                 zero;
    logic [2:0]           neg;
    logic [2:0][MW-1:0]   m;
  } side_t;

  // stage 1: magnitudes
  logic [GW-1:0] m1_r [3];
  logic [2:0]    neg1_r;
  // stage 2: largest magnitude
  logic [GW-1:0] m2_r [3];
  logic [2:0]    neg2_r;
  logic [GW-1:0] top2_r;
  // stage 3: leading-one position
  logic [GW-1:0] m3_r [3];
  logic [2:0]    neg3_r;
  logic [PW-1:0] pos3_r;
  logic          zero3_r;
  logic [PW-1:0] pos_nxt;
  // stage 4: normalized, stage 5: squares, stage 6: sum
  side_t         sd4_r, sd5_r, sd6_r;
  logic [2*MW-1:0] sq5_r [3];
  logic [SW-1:0] sum6_r;
  // root and divide pipelines
  logic [SW-1:0] rt_rem_r [NW];
  logic [NW-1:0] rt_q_r   [NW];
  side_t         rt_sd_r  [NW];
  logic [DW-1:0] dv_rem_r [QW][3];
  logic [QW-1:0] dv_q_r   [QW][3];
  logic [NW-1:0] dv_n_r   [QW];
  side_t         dv_sd_r  [QW];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1_r[i] <= d_in[i][GW-1];
        m1_r[i]   <= d_in[i][GW-1] ? GW'(-d_in[i]) : GW'(d_in[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r   <= m1_r;
      neg2_r <= neg1_r;
      if (m1_r[0] >= m1_r[1] && m1_r[0] >= m1_r[2]) begin
        top2_r <= m1_r[0];
      end else if (m1_r[1] >= m1_r[2]) begin
        top2_r <= m1_r[1];
      end else begin
        top2_r <= m1_r[2];
      end
    end
  end

  always_comb begin
    pos_nxt = '0;
    for (int b = 0; b < GW; b++) begin
      if (top2_r[b]) pos_nxt = PW'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_r    <= m2_r;
      neg3_r  <= neg2_r;
      pos3_r  <= pos_nxt;
      zero3_r <= (top2_r == '0);
    end
  end

  // shift all three together so the largest lands in [2^29, 2^30)
  always_ff @(posedge clk) begin
    logic [GW-1:0] s;
    if (en) begin
      sd4_r.zero <= zero3_r;
      sd4_r.neg  <= neg3_r;
      for (int i = 0; i < 3; i++) begin
        if (pos3_r >= PW'(ppls_pkg::NORM_MSB)) begin
          s = m3_r[i] >> (pos3_r - PW'(ppls_pkg::NORM_MSB));
        end else begin
          s = m3_r[i] << (PW'(ppls_pkg::NORM_MSB) - pos3_r);
        end
        sd4_r.m[i] <= s[MW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd5_r <= sd4_r;
      for (int i = 0; i < 3; i++) begin
        sq5_r[i] <= (2*MW)'(sd4_r.m[i]) * (2*MW)'(sd4_r.m[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd6_r  <= sd5_r;
      sum6_r <= SW'(sq5_r[0]) + SW'(sq5_r[1]) + SW'(sq5_r[2]);
    end
  end

  // restoring square root, one result bit per stage
  for (genvar k = 0; k < NW; k++) begin : g_root
    localparam int B = NW - 1 - k;
    logic [SW-1:0] rem_in;
    logic [NW-1:0] q_in;
    side_t         sd_in;
    logic [TW-1:0] trial;
    if (k == 0) begin : g_first
      assign rem_in = sum6_r;
      assign q_in   = '0;
      assign sd_in  = sd6_r;
    end else begin : g_next
      assign rem_in = rt_rem_r[k-1];
      assign q_in   = rt_q_r[k-1];
      assign sd_in  = rt_sd_r[k-1];
    end
    assign trial = (TW'(q_in) << (B + 1)) | (TW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        rt_sd_r[k] <= sd_in;
        if (TW'(rem_in) >= trial) begin
          rt_rem_r[k] <= rem_in - trial[SW-1:0];
          rt_q_r[k]   <= q_in | (NW'(1) << B);
        end else begin
          rt_rem_r[k] <= rem_in;
          rt_q_r[k]   <= q_in;
        end
      end
    end
  end

  // restoring divide (m << FRAC_BITS) / n, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int J = FRAC_BITS - k;
    logic [DW-1:0] rem_in [3];
    logic [QW-1:0] q_in   [3];
    logic [NW-1:0] n_in;
    side_t         sd_in;
    logic [DW-1:0] dvs;
    if (k == 0) begin : g_first
      assign n_in  = rt_q_r[NW-1];
      assign sd_in = rt_sd_r[NW-1];
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign rem_in[c] = DW'(rt_sd_r[NW-1].m[c]) << FRAC_BITS;
        assign q_in[c]   = '0;
      end
    end else begin : g_next
      assign n_in  = dv_n_r[k-1];
      assign sd_in = dv_sd_r[k-1];
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign rem_in[c] = dv_rem_r[k-1][c];
        assign q_in[c]   = dv_q_r[k-1][c];
      end
    end
    assign dvs = DW'(n_in) << J;
    always_ff @(posedge clk) begin
      if (en) begin
        dv_n_r[k]  <= n_in;
        dv_sd_r[k] <= sd_in;
        for (int c = 0; c < 3; c++) begin
          if (rem_in[c] >= dvs) begin
            dv_rem_r[k][c] <= rem_in[c] - dvs;
            dv_q_r[k][c]   <= q_in[c] | (QW'(1) << J);
          end else begin
            dv_rem_r[k][c] <= rem_in[c];
            dv_q_r[k][c]   <= q_in[c];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        if (dv_sd_r[QW-1].zero) begin
          u_out[c] <= '0;
        end else if (dv_sd_r[QW-1].neg[c]) begin
          u_out[c] <= -signed'(UW'(dv_q_r[QW-1][c]));
        end else begin
          u_out[c] <= signed'(UW'(dv_q_r[QW-1][c]));
        end
      end
    end
  end

endmodule

FILE: design/phong_point_light_shade_unit.sv
// ============================================================================
// phong_point_light_shade_unit
// Phong shading of one ray hit by one point light, fixed point.
// ============================================================================
// Takes one hit transaction per clock while the output is not stalled, and
// returns one shaded color transaction for each, in order. FRAC_BITS is 16 at
// the default Q16.16. The two vector normalizers dominate the depth, with one
// root bit per stage (31 stages) and one quotient bit per stage
// (FRAC_BITS + 1 stages), followed by 16 stages of dot products, reflection,
// the six squarings of the specular power and the color multiplies. All
// stages advance when the output register is empty or being taken, so a stall
// on the output side freezes every stage and drops nothing. Configuration
// registers are written through cfg_we / cfg_index / cfg_wdata and must only
// change while no transaction is in flight. No clearing pass after reset.
// ============================================================================
module phong_point_light_shade_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  ppls_in_if.sink                             in_s,
  ppls_out_if.source                          out_m,
  input  logic                                cfg_we,
  input  logic [ppls_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppls_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CW   = ppls_pkg::CRD_W;
  localparam int GW   = ppls_pkg::MAG_W;
  localparam int CHW  = ppls_pkg::CH_W;
  localparam int UNIT_LAT = 6 + ppls_pkg::SQRT_STEPS + FRAC_BITS + 2;
  localparam int LAST = UNIT_LAT + ppls_pkg::PACK_STAGES;
  localparam int LW   = FRAC_BITS + 2;        // unit vector component
  localparam int PLW  = LW + CW;              // l * n product
  localparam int LNW  = FRAC_BITS + 5;        // saturated l.n
  localparam int PRW  = LNW + CW;             // ln * n product
  localparam int RW   = PRW - FRAC_BITS + 3;  // reflection component
  localparam int RVW  = RW + LW;              // r * v product
  localparam int PW   = FRAC_BITS + 1;        // specular base in [0, 1]
  localparam int FW   = FRAC_BITS + 4;        // diffuse + specular
  localparam int FBW  = FW + ppls_pkg::BRIGHT_W;
  localparam int SCW  = FBW - ppls_pkg::BRIGHT_SHIFT;
  localparam int LCW  = CHW + SCW;
  localparam int TW   = LCW - FRAC_BITS + 1;
  localparam int OW   = TW + CHW;

  typedef struct packed {
    logic                          shadow;
    logic [ppls_pkg::COL_W-1:0]    surf;
    logic [2:0][CW-1:0]            nrm;
  } item_t;

  typedef struct packed {
    logic                          shadow;
    logic [ppls_pkg::COL_W-1:0]    surf;
  } tail_t;

  // ---------------------------------------------------------------- config
  logic signed [CW-1:0]          light_r [3];
  logic [ppls_pkg::COL_W-1:0]    light_color_r;
  logic [ppls_pkg::COL_W-1:0]    ambient_color_r;
  logic [CHW-1:0]                ratio_r;
  logic [CHW-1:0]                gain_r;
  logic [ppls_pkg::BRIGHT_W-1:0] bright_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) light_r[i] <= '0;
      light_color_r   <= '0;
      ambient_color_r <= '0;
      ratio_r         <= ppls_pkg::RATIO_RST;
      gain_r          <= ppls_pkg::GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ppls_pkg::REG_LIGHT_X:       light_r[0]      <= signed'(cfg_wdata[CW-1:0]);
        ppls_pkg::REG_LIGHT_Y:       light_r[1]      <= signed'(cfg_wdata[CW-1:0]);
        ppls_pkg::REG_LIGHT_Z:       light_r[2]      <= signed'(cfg_wdata[CW-1:0]);
        ppls_pkg::REG_LIGHT_COLOR:   light_color_r   <= cfg_wdata;
        ppls_pkg::REG_AMBIENT_COLOR: ambient_color_r <= cfg_wdata;
        ppls_pkg::REG_LIGHT_RATIO:   ratio_r         <= cfg_wdata[CHW-1:0];
        ppls_pkg::REG_LUMEN_GAIN:    gain_r          <= cfg_wdata[CHW-1:0];
        default: ;  // index past the register list: ignored
      endcase
    end
  end

  // brightness in Q.27; settles long before any transaction needs it
  always_ff @(posedge clk) begin
    bright_r <= ppls_pkg::BRIGHT_W'(ratio_r) * ppls_pkg::BRIGHT_W'(gain_r);
  end

  // ------------------------------------------------------- pipeline control
  logic            adv;
  logic [LAST:0]   vld_r;

  assign adv         = !vld_r[LAST] || out_m.ready;
  assign in_s.ready  = adv;
  assign out_m.valid = vld_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAST-1:0], in_s.valid};
    end
  end

  // ------------------------------------------- stage 0: light and view vectors
  logic signed [GW-1:0] d0_r  [3];
  logic signed [GW-1:0] vd0_r [3];
  item_t                dly_r [UNIT_LAT+1];
  logic signed [CW-1:0] hit_w [3];
  logic signed [CW-1:0] view_w [3];

  assign hit_w  = '{in_s.hit_x, in_s.hit_y, in_s.hit_z};
  assign view_w = '{in_s.ray_dir_x, in_s.ray_dir_y, in_s.ray_dir_z};

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d0_r[i]  <= GW'(light_r[i]) - GW'(hit_w[i]);
        vd0_r[i] <= -GW'(view_w[i]);
      end
      dly_r[0].shadow <= in_s.shadowed;
      dly_r[0].surf   <= in_s.surface_color;
      dly_r[0].nrm    <= {in_s.normal_x, in_s.normal_y, in_s.normal_z};
      for (int k = 1; k <= UNIT_LAT; k++) dly_r[k] <= dly_r[k-1];
    end
  end

  // normalizers: l = unit(light - hit), v = unit(-ray_dir)
  logic signed [LW-1:0] l_u [3];
  logic signed [LW-1:0] v_u [3];

  ppls_unit #(.FRAC_BITS(FRAC_BITS)) u_norm_l (
    .clk   (clk),
    .en    (adv),
    .d_in  (d0_r),
    .u_out (l_u)
  );

  ppls_unit #(.FRAC_BITS(FRAC_BITS)) u_norm_v (
    .clk   (clk),
    .en    (adv),
    .d_in  (vd0_r),
    .u_out (v_u)
  );

  // normal is packed x high: index 2 - i gives component i
  item_t                it_u;
  assign it_u = dly_r[UNIT_LAT];

  // -------------------------------------------------------- P1: l * n terms
  logic signed [PLW-1:0] p1_ln_r [3];
  logic signed [LW-1:0]  p1_l_r [3], p1_v_r [3];
  item_t                 p1_it_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p1_ln_r[i] <= PLW'(l_u[i]) * PLW'(signed'(it_u.nrm[2-i]));
      end
      p1_l_r  <= l_u;
      p1_v_r  <= v_u;
      p1_it_r <= it_u;
    end
  end

  // -------------------------------------------- P2: l.n, saturated to +-8.0
  logic signed [PLW+1:0] ln_sum;
  logic signed [PLW+1:0] ln_sh;
  logic signed [LNW-1:0] p2_ln_r;
  logic signed [LW-1:0]  p2_l_r [3], p2_v_r [3];
  item_t                 p2_it_r;
  localparam logic signed [PLW+1:0] LN_SAT = (PLW+2)'(8) <<< FRAC_BITS;

  assign ln_sum = (PLW+2)'(p1_ln_r[0]) + (PLW+2)'(p1_ln_r[1]) + (PLW+2)'(p1_ln_r[2]);
  assign ln_sh  = ln_sum >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ln_sh > LN_SAT) begin
        p2_ln_r <= LNW'(LN_SAT);
      end else if (ln_sh < -LN_SAT) begin
        p2_ln_r <= LNW'(-LN_SAT);
      end else begin
        p2_ln_r <= LNW'(ln_sh);
      end
      p2_l_r  <= p1_l_r;
      p2_v_r  <= p1_v_r;
      p2_it_r <= p1_it_r;
    end
  end

  // ----------------------------------------------------- P3: ln * n terms
  logic signed [PRW-1:0] p3_rn_r [3];
  logic signed [LNW-1:0] p3_ln_r;
  logic signed [LW-1:0]  p3_l_r [3], p3_v_r [3];
  tail_t                 p3_tl_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p3_rn_r[i] <= PRW'(p2_ln_r) * PRW'(signed'(p2_it_r.nrm[2-i]));
      end
      p3_ln_r        <= p2_ln_r;
      p3_l_r         <= p2_l_r;
      p3_v_r         <= p2_v_r;
      p3_tl_r.shadow <= p2_it_r.shadow;
      p3_tl_r.surf   <= p2_it_r.surf;
    end
  end

  // ------------------------------------- P4: reflection r = 2(l.n)n - l
  logic signed [RW-1:0]  p4_r_r [3];
  logic signed [LNW-1:0] p4_ln_r;
  logic signed [LW-1:0]  p4_v_r [3];
  tail_t                 p4_tl_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        // floor(2x / 2^F) == floor(x / 2^(F-1))
        p4_r_r[i] <= RW'(p3_rn_r[i] >>> (FRAC_BITS - 1)) - RW'(p3_l_r[i]);
      end
      p4_ln_r <= p3_ln_r;
      p4_v_r  <= p3_v_r;
      p4_tl_r <= p3_tl_r;
    end
  end

  // ------------------------------------------------------ P5: r * v terms
  logic signed [RVW-1:0] p5_rv_r [3];
  logic signed [LNW-1:0] p5_ln_r;
  tail_t                 p5_tl_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p5_rv_r[i] <= RVW'(p4_r_r[i]) * RVW'(p4_v_r[i]);
      end
      p5_ln_r <= p4_ln_r;
      p5_tl_r <= p4_tl_r;
    end
  end

  // ------------------------------------------ P6: r.v clamped to [0, 1.0]
  logic signed [RVW+1:0] rv_sum;
  logic signed [RVW+1:0] rv_sh;
  logic [PW-1:0]         p6_p_r;
  logic signed [LNW-1:0] p6_ln_r;
  tail_t                 p6_tl_r;
  localparam logic signed [RVW+1:0] RV_ONE = (RVW+2)'(1) <<< FRAC_BITS;

  assign rv_sum = (RVW+2)'(p5_rv_r[0]) + (RVW+2)'(p5_rv_r[1]) + (RVW+2)'(p5_rv_r[2]);
  assign rv_sh  = rv_sum >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (rv_sh < 0) begin
        p6_p_r <= '0;
      end else if (rv_sh > RV_ONE) begin
        p6_p_r <= PW'(RV_ONE);
      end else begin
        p6_p_r <= PW'(rv_sh);
      end
      p6_ln_r <= p5_ln_r;
      p6_tl_r <= p5_tl_r;
    end
  end

  // --------------------------------------- P7..P12: six squarings, x^64
  logic [PW-1:0]         pw_r    [6];
  logic signed [LNW-1:0] pw_ln_r [6];
  tail_t                 pw_tl_r [6];

  for (genvar k = 0; k < 6; k++) begin : g_pow
    logic [PW-1:0]         p_in;
    logic signed [LNW-1:0] ln_in;
    tail_t                 tl_in;
    logic [2*PW-1:0]       sq;
    if (k == 0) begin : g_first
      assign p_in  = p6_p_r;
      assign ln_in = p6_ln_r;
      assign tl_in = p6_tl_r;
    end else begin : g_next
      assign p_in  = pw_r[k-1];
      assign ln_in = pw_ln_r[k-1];
      assign tl_in = pw_tl_r[k-1];
    end
    assign sq = (2*PW)'(p_in) * (2*PW)'(p_in);
    always_ff @(posedge clk) begin
      if (adv) begin
        pw_r[k]    <= PW'(sq >> FRAC_BITS);
        pw_ln_r[k] <= ln_in;
        pw_tl_r[k] <= tl_in;
      end
    end
  end

  // ---------------------- P13: (diffuse + specular / 2) * brightness, zero when shadowed
  logic [FW-1:0]  factor;
  logic [FBW-1:0] p13_fb_r;
  tail_t          p13_tl_r;

  always_comb begin
    if (pw_tl_r[5].shadow) begin
      factor = '0;
    end else if (pw_ln_r[5] > 0) begin
      factor = FW'(pw_ln_r[5]) + FW'(pw_r[5] >> 1);
    end else begin
      factor = FW'(pw_r[5] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p13_fb_r <= FBW'(factor) * FBW'(bright_r);
      p13_tl_r <= pw_tl_r[5];
    end
  end

  // ------------------------------------------ P14: light channel * scale
  logic [SCW-1:0] scale;
  logic [LCW-1:0] p14_lc_r [3];
  tail_t          p14_tl_r;

  assign scale = SCW'(p13_fb_r >> ppls_pkg::BRIGHT_SHIFT);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        p14_lc_r[c] <= LCW'(light_color_r[CHW*(2-c) +: CHW]) * LCW'(scale);
      end
      p14_tl_r <= p13_tl_r;
    end
  end

  // ----------------------------- P15: (light + ambient) * surface channel
  logic [TW-1:0] t_ch [3];
  logic [OW-1:0] p15_o_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      t_ch[c] = TW'(p14_lc_r[c] >> FRAC_BITS) + TW'(ambient_color_r[CHW*(2-c) +: CHW]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        p15_o_r[c] <= OW'(t_ch[c]) * OW'(p14_tl_r.surf[CHW*(2-c) +: CHW]);
      end
    end
  end

  // --------------------------------------- P16: scale down, clamp to 1.0
  logic [OW-1:0]  o_sh [3];
  logic [CHW-1:0] o_ch [3];
  logic [CHW-1:0] out_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      o_sh[c] = p15_o_r[c] >> ppls_pkg::COLOR_SHIFT;
      o_ch[c] = (o_sh[c] > OW'(ppls_pkg::CH_ONE)) ? ppls_pkg::CH_ONE : o_sh[c][CHW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= o_ch;
    end
  end

  assign out_m.out_red   = out_r[0];
  assign out_m.out_green = out_r[1];
  assign out_m.out_blue  = out_r[2];

endmodule

FILE: tb/sv/tb_phong_point_light_shade_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_phong_point_light_shade_unit
// Self-checking bench for the Phong point-light shading pipeline.
// ============================================================================
// A directed table of hits, then random hits under several light settings.
// Every accepted hit is scored by a fixed-point shading model in this file
// and its expected color (hand-computed for some directed rows) is queued;
// each color transaction is compared against the oldest queued entry.
// ============================================================================
module tb_phong_point_light_shade_unit;

  localparam int FRAC    = 16;
  localparam int LATENCY = FRAC + 55;

  typedef struct {
    logic signed [31:0] hit [3];
    logic signed [31:0] nrm [3];
    logic signed [31:0] vdir [3];
    logic [47:0]        surf;
    logic               shadow;
  } hit_item_t;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } shade_t;

  // directed table row: item plus optional hand-computed color
  typedef struct {
    hit_item_t item;
    bit        known;
    shade_t    color;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ppls_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ppls_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ppls_in_if  in_ch ();
  ppls_out_if out_ch ();

  phong_point_light_shade_unit #(.FRAC_BITS(FRAC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_ch.sink),
    .out_m     (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // bench copy of the light registers
  logic [63:0] light_regs [7];

  shade_t color_q [$];
  int     mismatches;
  bit     hold_output;     // long receiver hold-off request
  bit     stall_enable;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point shading model
  // ---------------------------------------------------------------------------
  function automatic longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // unit vector in Q.FRAC; zero in, zero out
  function automatic void to_unit(input longint d [3], output longint u [3]);
    longint unsigned m [3];
    longint unsigned top, sq, nrm, q;
    bit neg [3];
    top = 0;
    sq  = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = d[i] < 0;
      m[i]   = neg[i] ? -d[i] : d[i];
      if (m[i] > top) top = m[i];
    end
    if (top == 0) begin
      u[0] = 0; u[1] = 0; u[2] = 0;
    end else begin
      while (top >= (64'd1 << 30)) begin
        for (int i = 0; i < 3; i++) m[i] >>= 1;
        top >>= 1;
      end
      while (top < (64'd1 << 29)) begin
        for (int i = 0; i < 3; i++) m[i] <<= 1;
        top <<= 1;
      end
      for (int i = 0; i < 3; i++) sq += m[i] * m[i];
      nrm = int_sqrt(sq);
      for (int i = 0; i < 3; i++) begin
        q    = (m[i] << FRAC) / nrm;
        u[i] = neg[i] ? -longint'(q) : longint'(q);
      end
    end
  endfunction

  task automatic shade_hit(input hit_item_t it, output shade_t res);
    longint d [3], vd [3], l [3], v [3], r [3], n [3];
    longint ln, rv;
    longint unsigned p, factor, bright, scale, lc, ac, sc, t, o;
    logic [15:0] ch [3];
    longint ln_sat, one;
    ln_sat = longint'(8) << FRAC;
    one    = longint'(1) << FRAC;
    factor = 0;
    for (int i = 0; i < 3; i++) begin
      n[i]  = it.nrm[i];
      vd[i] = -longint'(it.vdir[i]);
      d[i]  = longint'($signed(light_regs[i][31:0])) - longint'(it.hit[i]);
    end
    if (!it.shadow) begin
      to_unit(d, l);
      to_unit(vd, v);
      ln = fl_shr(l[0]*n[0] + l[1]*n[1] + l[2]*n[2], FRAC);
      if (ln > ln_sat) ln = ln_sat;
      if (ln < -ln_sat) ln = -ln_sat;
      for (int i = 0; i < 3; i++) r[i] = fl_shr(2 * ln * n[i], FRAC) - l[i];
      rv = fl_shr(r[0]*v[0] + r[1]*v[1] + r[2]*v[2], FRAC);
      if (rv < 0) rv = 0;
      if (rv > one) rv = one;
      p = rv;
      repeat (6) p = (p * p) >> FRAC;  // power of 64
      factor = (ln > 0 ? longint'(ln) : 0) + (p >> 1);
    end
    bright = light_regs[ppls_pkg::REG_LIGHT_RATIO][15:0] *
             light_regs[ppls_pkg::REG_LUMEN_GAIN][15:0];
    scale  = (factor * bright) >> ppls_pkg::BRIGHT_SHIFT;
    for (int k = 0; k < 3; k++) begin
      lc = (light_regs[ppls_pkg::REG_LIGHT_COLOR] >> (32 - 16*k)) & 64'hFFFF;
      ac = (light_regs[ppls_pkg::REG_AMBIENT_COLOR] >> (32 - 16*k)) & 64'hFFFF;
      sc = (it.surf >> (32 - 16*k)) & 64'hFFFF;
      t  = ((lc * scale) >> FRAC) + ac;
      o  = (t * sc) >> ppls_pkg::COLOR_SHIFT;
      if (o > ppls_pkg::CH_ONE) o = ppls_pkg::CH_ONE;
      ch[k] = o[15:0];
    end
    res.red = ch[0]; res.green = ch[1]; res.blue = ch[2];
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000 | ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 0);
      2: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
      default: return $signed($urandom_range(0, 400000)) - 200000;
    endcase
  endfunction

  function automatic hit_item_t rnd_hit();
    hit_item_t it;
    longint d [3], u [3];
    for (int i = 0; i < 3; i++) begin
      it.hit[i]  = rnd_coord();
      it.vdir[i] = rnd_coord();
      d[i] = $signed($urandom_range(0, 2000)) - 1000;
    end
    if ($urandom_range(0, 9) < 7) begin
      // mostly unit normals so diffuse/specular are meaningful
      if (d[0] == 0 && d[1] == 0 && d[2] == 0) d[2] = 1;
      to_unit(d, u);
      for (int i = 0; i < 3; i++) it.nrm[i] = 32'(u[i]);
    end else begin
      for (int i = 0; i < 3; i++) it.nrm[i] = rnd_coord();
    end
    if ($urandom_range(0, 3) == 0) it.surf = 48'({$urandom, $urandom});
    else it.surf = {16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                    16'($urandom_range(0, 32768))};
    it.shadow = ($urandom_range(0, 4) == 0);
    return it;
  endfunction

  function automatic hit_item_t mk_hit(longint hx, longint hy, longint hz,
                                       longint nx, longint ny, longint nz,
                                       longint vx, longint vy, longint vz,
                                       logic [47:0] surf, logic sh);
    hit_item_t it;
    it.hit[0] = 32'(hx);  it.hit[1] = 32'(hy);  it.hit[2] = 32'(hz);
    it.nrm[0] = 32'(nx);  it.nrm[1] = 32'(ny);  it.nrm[2] = 32'(nz);
    it.vdir[0] = 32'(vx); it.vdir[1] = 32'(vy); it.vdir[2] = 32'(vz);
    it.surf = surf;
    it.shadow = sh;
    return it;
  endfunction

  // one register write, then cfg_we low again before returning
  task automatic write_reg(input ppls_pkg::cfg_reg_t idx, input logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      ppls_pkg::REG_LIGHT_X, ppls_pkg::REG_LIGHT_Y, ppls_pkg::REG_LIGHT_Z:
        light_regs[idx] = 64'(val[31:0]);
      ppls_pkg::REG_LIGHT_RATIO, ppls_pkg::REG_LUMEN_GAIN:
        light_regs[idx] = 64'(val[15:0]);
      default:
        light_regs[idx] = 64'(val);
    endcase
    @(posedge clk);
  endtask

  // index beyond the register list must be ignored
  task automatic write_bad_index();
    cfg_we    <= 1'b1;
    cfg_index <= 3'd7;
    cfg_wdata <= 48'({$urandom, $urandom});
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // idle between phases: drain, then let the pipe settle
  task automatic wait_idle();
    while (color_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // offer one hit and wait until it is taken; queue the prediction or given color
  task automatic send_hit(input hit_item_t it, input bit known, input shade_t want);
    shade_t pred;
    in_ch.valid         <= 1'b1;
    in_ch.hit_x         <= it.hit[0];
    in_ch.hit_y         <= it.hit[1];
    in_ch.hit_z         <= it.hit[2];
    in_ch.normal_x      <= it.nrm[0];
    in_ch.normal_y      <= it.nrm[1];
    in_ch.normal_z      <= it.nrm[2];
    in_ch.ray_dir_x     <= it.vdir[0];
    in_ch.ray_dir_y     <= it.vdir[1];
    in_ch.ray_dir_z     <= it.vdir[2];
    in_ch.surface_color <= it.surf;
    in_ch.shadowed      <= it.shadow;
    do @(posedge clk); while (!in_ch.ready);
    shade_hit(it, pred);
    color_q.push_back(known ? want : pred);
  endtask

  task automatic send_burst(input int count);
    int burst;
    shade_t none;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && count > 0; i++, count--) send_hit(rnd_hit(), 0, none);
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic rnd_light();
    write_reg(ppls_pkg::REG_LIGHT_X, 48'(rnd_coord()));
    write_reg(ppls_pkg::REG_LIGHT_Y, 48'(rnd_coord()));
    write_reg(ppls_pkg::REG_LIGHT_Z, 48'(rnd_coord()));
    write_reg(ppls_pkg::REG_LIGHT_COLOR, 48'({$urandom, $urandom}));
    write_reg(ppls_pkg::REG_AMBIENT_COLOR, $urandom_range(0, 1) ? 48'({$urandom, $urandom}) :
              {16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
               16'($urandom_range(0, 8000))});
    write_reg(ppls_pkg::REG_LIGHT_RATIO, 48'($urandom_range(0, 1) ? 16'($urandom) :
              16'($urandom_range(0, 32768))));
    write_reg(ppls_pkg::REG_LUMEN_GAIN, 48'(16'($urandom)));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t    rows [$];
    dir_row_t    row;
    shade_t      none;
    logic [47:0] full_white;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    hold_output  = 1'b0;
    stall_enable = 1'b0;
    mismatches   = 0;
    none         = '{0, 0, 0};
    full_white   = {16'd32768, 16'd32768, 16'd32768};
    in_ch.valid = 1'b0;
    in_ch.hit_x = '0; in_ch.hit_y = '0; in_ch.hit_z = '0;
    in_ch.normal_x = '0; in_ch.normal_y = '0; in_ch.normal_z = '0;
    in_ch.ray_dir_x = '0; in_ch.ray_dir_y = '0; in_ch.ray_dir_z = '0;
    in_ch.surface_color = '0;
    in_ch.shadowed = 1'b0;
    for (int i = 0; i < 7; i++) light_regs[i] = 0;
    light_regs[ppls_pkg::REG_LIGHT_RATIO] = 32768;
    light_regs[ppls_pkg::REG_LUMEN_GAIN]  = 4096;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset light and ambient colors are black: every hit shades to 0.
    row = '{mk_hit(0, 0, 0, 0, 0, 1 << 16, 0, 0, -(1 << 16), full_white, 0), 1, none};
    rows.push_back(row);
    row = '{mk_hit(-2147483648, 2147483647, 0, 0, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 1),
            1, none};
    rows.push_back(row);
    foreach (rows[i]) send_hit(rows[i].item, rows[i].known, rows[i].color);
    in_ch.valid <= 1'b0;
    wait_idle();

    // white ambient, white light overhead at z = +4
    write_reg(ppls_pkg::REG_AMBIENT_COLOR, full_white);
    write_reg(ppls_pkg::REG_LIGHT_COLOR, full_white);
    write_bad_index();
    write_reg(ppls_pkg::REG_LIGHT_Z, 48'(4 << 16));
    rows.delete();
    // shadowed hit: ambient * surface only
    row = '{mk_hit(0, 0, 0, 0, 0, 1 << 16, 0, 0, -(1 << 16), full_white, 1), 1,
            '{16'd32768, 16'd32768, 16'd32768}};
    rows.push_back(row);
    row = '{mk_hit(0, 0, 0, 0, 0, 1 << 16, 0, 0, -(1 << 16),
                   {16'd16384, 16'd0, 16'd8192}, 1), 1, '{16'd16384, 16'd0, 16'd8192}};
    rows.push_back(row);
    // zero surface: black whatever the light
    row = '{mk_hit(0, 0, 0, 0, 0, 1 << 16, 0, 0, -(1 << 16), 48'h0, 0), 1, none};
    rows.push_back(row);
    // remaining rows checked by the model
    rows.push_back('{mk_hit(0, 0, 0, 0, 0, 1 << 16, 0, 0, -(1 << 16),
                            48'h0000_4000_2000, 0), 0, none});
    // light at the hit point
    rows.push_back('{mk_hit(0, 0, 4 << 16, 0, 0, 1 << 16, 1 << 16, 0, 0,
                            48'h1000_1000_1000, 0), 0, none});
    // zero view direction
    rows.push_back('{mk_hit(1 << 16, 0, 0, 0, 0, 1 << 16, 0, 0, 0,
                            48'h2000_3000_4000, 0), 0, none});
    // non-unit normals, both saturations
    rows.push_back('{mk_hit(0, 0, 0, 0, 0, 2147483647, 0, 0, -1, 48'h0100_0100_0100, 0),
                     0, none});
    rows.push_back('{mk_hit(0, 0, 0, 0, 0, -2147483648, 0, 0, -1, 48'h0100_0100_0100, 0),
                     0, none});
    rows.push_back('{mk_hit(2147483647, -2147483648, -2147483648, 1, -1, 0,
                            -2147483648, 2147483647, 1, 48'hFFFF_FFFF_FFFF, 0), 0, none});
    rows.push_back('{mk_hit(-1, -1, -1, -2147483648, -2147483648, -2147483648,
                            2147483647, 2147483647, 2147483647, 48'hFFFF_FFFF_FFFF, 0),
                     0, none});
    rows.push_back('{mk_hit(0, 0, -(1 << 16), 0, 0, 1 << 16, 0, 1 << 16, 0,
                            48'h8000_8000_8000, 0), 0, none});
    for (int i = 3; i < rows.size(); i++) send_hit(rows[i].item, 0, none);
    for (int i = 0; i < 3; i++) send_hit(rows[i].item, rows[i].known, rows[i].color);
    in_ch.valid <= 1'b0;
    wait_idle();

    // extreme settings: max ratio/gain, light at the far corner
    write_reg(ppls_pkg::REG_LIGHT_RATIO, 48'hFFFF);
    write_reg(ppls_pkg::REG_LUMEN_GAIN, 48'hFFFF);
    write_reg(ppls_pkg::REG_LIGHT_X, 48'h8000_0000);
    write_reg(ppls_pkg::REG_LIGHT_Y, 48'h7FFF_FFFF);
    write_reg(ppls_pkg::REG_LIGHT_Z, 48'h8000_0000);
    write_reg(ppls_pkg::REG_AMBIENT_COLOR, 48'h0);
    write_reg(ppls_pkg::REG_LIGHT_COLOR, 48'hFFFF_FFFF_FFFF);
    send_burst(100);
    wait_idle();
    write_reg(ppls_pkg::REG_LIGHT_RATIO, 48'h0);
    write_reg(ppls_pkg::REG_LUMEN_GAIN, 48'h0);
    send_burst(60);
    wait_idle();

    // random phases with output stalls enabled
    stall_enable = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      rnd_light();
      write_reg(ppls_pkg::REG_LIGHT_RATIO,
                48'(ph == 0 ? 16'd32768 : light_regs[ppls_pkg::REG_LIGHT_RATIO][15:0]));
      if (ph == 2) begin
        // long receiver hold-off while the sender keeps offering
        hold_output = 1'b1;
        send_burst(250);
        hold_output = 1'b0;
      end else begin
        send_burst(250);
      end
      wait_idle();  // sender pause until every color has come back
    end

    repeat (LATENCY + 20) @(posedge clk);
    if (color_q.size() == 0 && mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: stall pattern, plus a counted long hold-off on request
  initial begin
    int hold_cnt;
    out_ch.ready = 1'b0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_output && hold_cnt < 400) begin
        hold_cnt++;
        out_ch.ready <= 1'b0;
      end else if (!stall_enable) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 15) < 11);
      end
    end
  end

  // scoreboard
  always @(posedge clk) begin
    shade_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (color_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected color transaction at %0t", $time);
      end else begin
        want = color_q.pop_front();
        if (out_ch.out_red !== want.red || out_ch.out_green !== want.green ||
            out_ch.out_blue !== want.blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("color mismatch at %0t: expected %0d/%0d/%0d got %0d/%0d/%0d",
                     $time, want.red, want.green, want.blue,
                     out_ch.out_red, out_ch.out_green, out_ch.out_blue);
        end
      end
    end
  end

  // watchdog
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
